// ----- hw/rtl/state_variable_filter_assert.svh -----
// Assertion macros for the state variable filter.
// Used by the top level; relies on clk and rst_n being in scope where expanded.
`ifndef STATE_VARIABLE_FILTER_ASSERT_SVH
`define STATE_VARIABLE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SVF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("state_variable_filter assertion failed");
// Next-cycle implication, disabled during reset.
`define SVF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("state_variable_filter assertion failed");
`else
`define SVF_ASSERT_NOW(lbl, ante, cons)
`define SVF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/svf_pkg.sv -----
// Shared constants, control word type and microcode table of the state variable filter.
// No dependencies.
package svf_pkg;

    // Default widths of the filter.
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int STATE_BITS_DEF     = 24;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Coefficient registers are always 15 bits unsigned.
    localparam int COEF_BITS = 15;
    localparam logic [COEF_BITS-1:0] FREQ_RESET = 15'd1024;
    localparam logic [COEF_BITS-1:0] DAMP_RESET = 15'd16384;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_COEF    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING_COEF = 2'd1;

    // Step counter of the microprogram.
    localparam int STEP_BITS = 3;

    // Multiplier operand selects.
    localparam logic MULA_BAND = 1'b0;
    localparam logic MULA_HIGH = 1'b1;
    localparam logic COEF_Q    = 1'b0;
    localparam logic COEF_F    = 1'b1;

    // Accumulate and write-back targets.
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_HIGH = 2'd1;
    localparam logic [1:0] WR_BAND = 2'd2;
    localparam logic [1:0] WR_LOW  = 2'd3;

    // Step conditions: hold at the step until the condition is met.
    localparam logic [1:0] COND_NONE     = 2'd0;
    localparam logic [1:0] COND_IN_WORD  = 2'd1;
    localparam logic [1:0] COND_OUT_FREE = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic       mul_a_sel;
        logic       coef_sel;
        logic [1:0] wr_sel;
        logic [1:0] cond;
        logic       last;
    } ctrl_word_t;

    // Control toward the datapath: the current word and whether the step retires.
    typedef struct packed {
        ctrl_word_t cw;
        logic       fire;
    } seq_ctrl_t;

    // Microprogram: one sample per pass through the six steps.
    function automatic ctrl_word_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ctrl_word_t w;
        w = '{mul_en: 1'b0, mul_a_sel: MULA_BAND, coef_sel: COEF_Q,
              wr_sel: WR_NONE, cond: COND_NONE, last: 1'b0};
        case (step)
            3'd0:
            begin
                // Wait for a sample; start q*band.
                w.mul_en    = 1'b1;
                w.mul_a_sel = MULA_BAND;
                w.coef_sel  = COEF_Q;
                w.cond      = COND_IN_WORD;
            end
            3'd1:
            begin
                w.wr_sel = WR_HIGH;
            end
            3'd2:
            begin
                w.mul_en    = 1'b1;
                w.mul_a_sel = MULA_HIGH;
                w.coef_sel  = COEF_F;
            end
            3'd3:
            begin
                w.wr_sel = WR_BAND;
            end
            3'd4:
            begin
                w.mul_en    = 1'b1;
                w.mul_a_sel = MULA_BAND;
                w.coef_sel  = COEF_F;
            end
            3'd5:
            begin
                // Finish low and hand the word to the output register.
                w.wr_sel = WR_LOW;
                w.cond   = COND_OUT_FREE;
                w.last   = 1'b1;
            end
            default:
            begin
                // Unused steps return to the start.
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/state_variable_filter.sv -----
// Top level of the state variable filter: config registers, output register, assertions.
// Depends on svf_pkg, svf_sequencer, svf_datapath and state_variable_filter_assert.svh.

// Chamberlin state variable filter. Each input word is one signed sample; each
// output word carries the highpass, bandpass and lowpass values of that sample,
// saturated to the state width. One sample runs through six microcode steps, the
// accepting step included: the three coefficient products (q*band, f*high, f*band)
// each depend on the previous result and go through the one shared multiplier, a
// multiply step followed by a round, accumulate and saturate step. The result is
// loaded into the output register when the last step retires. A new sample is
// accepted as soon as the microprogram returns to its first step, not before, while
// the previous result may still wait in the output register; if that register is
// still full at the last step, the sequencer holds there while the output stalls.
// Coefficients are written through the configuration port (index 0 tuning, index 1
// damping); other indexes are ignored. They are to be written only while idle; the
// block itself does not enforce this. Reset clears both integrators.
module state_variable_filter #(
    parameter int SAMPLE_BITS    = svf_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS     = svf_pkg::STATE_BITS_DEF,
    parameter int COEF_FRAC_BITS = svf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [STATE_BITS-1:0]          highpass_out,
    output logic signed [STATE_BITS-1:0]          bandpass_out,
    output logic signed [STATE_BITS-1:0]          lowpass_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [svf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [svf_pkg::COEF_BITS-1:0]         cfg_data
);

    `include "state_variable_filter_assert.svh"

    logic [svf_pkg::COEF_BITS-1:0] freq_coef_reg, freq_coef_next;
    logic [svf_pkg::COEF_BITS-1:0] damping_coef_reg, damping_coef_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [STATE_BITS-1:0]  highpass_reg, highpass_next;
    logic signed [STATE_BITS-1:0]  bandpass_reg, bandpass_next;
    logic signed [STATE_BITS-1:0]  lowpass_reg, lowpass_next;

    svf_pkg::seq_ctrl_t            ctrl;
    logic                          out_free;
    logic                          load_out;
    logic signed [STATE_BITS-1:0]  high_value, band_value, acc_value;

    // Configuration registers; the port never stalls.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        freq_coef_next    = freq_coef_reg;
        damping_coef_next = damping_coef_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                svf_pkg::REG_FREQ_COEF:    freq_coef_next    = cfg_data;
                svf_pkg::REG_DAMPING_COEF: damping_coef_next = cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_coef_reg    <= svf_pkg::FREQ_RESET;
            damping_coef_reg <= svf_pkg::DAMP_RESET;
        end
        else
        begin
            freq_coef_reg    <= freq_coef_next;
            damping_coef_reg <= damping_coef_next;
        end
    end

    // Sequencer and datapath.
    assign out_free = !out_valid_reg || out_ready;

    svf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    svf_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .STATE_BITS     (STATE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sample_in    (sample_in),
        .freq_coef    (freq_coef_reg),
        .damping_coef (damping_coef_reg),
        .high_value   (high_value),
        .band_value   (band_value),
        .acc_value    (acc_value)
    );

    // Output register: loaded when the last step retires.
    assign load_out = ctrl.fire && ctrl.cw.last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        highpass_next  = highpass_reg;
        bandpass_next  = bandpass_reg;
        lowpass_next   = lowpass_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            highpass_next  = high_value;
            bandpass_next  = band_value;
            lowpass_next   = acc_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        highpass_reg <= highpass_next;
        bandpass_reg <= bandpass_next;
        lowpass_reg  <= lowpass_next;
    end

    assign out_valid    = out_valid_reg;
    assign highpass_out = highpass_reg;
    assign bandpass_out = bandpass_reg;
    assign lowpass_out  = lowpass_reg;

    // The sequencer is busy for the rest of the sample after taking a word.
    `SVF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // Retiring the last step always leaves a result waiting.
    `SVF_ASSERT_NEXT(a_result_loaded, load_out, out_valid_reg)
    // A result is never written over while it is still waiting.
    `SVF_ASSERT_NOW(a_no_overwrite, load_out, !out_valid_reg || out_ready)
    // Input is only taken at the step that waits for it.
    `SVF_ASSERT_NOW(a_accept_at_start, in_ready, ctrl.cw.mul_en && !ctrl.cw.last)

endmodule

// ----- hw/rtl/svf_sequencer.sv -----
// Step counter and microcode decode of the state variable filter.
// Depends on svf_pkg.
module svf_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    output logic                in_ready,
    output svf_pkg::seq_ctrl_t  ctrl
);

    logic [svf_pkg::STEP_BITS-1:0] step_reg;
    logic [svf_pkg::STEP_BITS-1:0] step_next;
    svf_pkg::ctrl_word_t           cw;
    logic                          advance;

    // Fetch the control word of the current step.
    assign cw = svf_pkg::ucode_rom(step_reg);

    // Evaluate the step condition.
    always_comb
    begin
        case (cw.cond)
            svf_pkg::COND_IN_WORD:  advance = in_valid;
            svf_pkg::COND_OUT_FREE: advance = out_free;
            default:                advance = 1'b1;
        endcase
    end

    assign in_ready  = (cw.cond == svf_pkg::COND_IN_WORD);
    assign ctrl.cw   = cw;
    assign ctrl.fire = advance;

    // Next step: hold, advance, or jump back to the start.
    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            if (cw.last)
                step_next = '0;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

endmodule

// ----- hw/rtl/svf_datapath.sv -----
// Multiplier, rounding, accumulate and saturate datapath with the filter state.
// Depends on svf_pkg; driven by svf_sequencer control words.
module svf_datapath #(
    parameter int SAMPLE_BITS    = svf_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS     = svf_pkg::STATE_BITS_DEF,
    parameter int COEF_FRAC_BITS = svf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  svf_pkg::seq_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic [svf_pkg::COEF_BITS-1:0]       freq_coef,
    input  logic [svf_pkg::COEF_BITS-1:0]       damping_coef,
    output logic signed [STATE_BITS-1:0]        high_value,
    output logic signed [STATE_BITS-1:0]        band_value,
    output logic signed [STATE_BITS-1:0]        acc_value
);

    // Product, rounded product and accumulator widths.
    localparam int PROD_BITS = STATE_BITS + svf_pkg::COEF_BITS + 1;
    localparam int RND_BITS  = PROD_BITS - COEF_FRAC_BITS;
    localparam int MAX_A     = (RND_BITS > STATE_BITS) ? RND_BITS : STATE_BITS;
    localparam int MAX_B     = (MAX_A > SAMPLE_BITS) ? MAX_A : SAMPLE_BITS;
    localparam int SUM_BITS  = MAX_B + 2;

    localparam logic signed [PROD_BITS-1:0] HALF_LSB =
        {{(PROD_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0] SAT_MAX =
        {{(SUM_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_MIN =
        {{(SUM_BITS-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic signed [STATE_BITS-1:0]  high_reg, high_next;
    logic signed [STATE_BITS-1:0]  band_reg, band_next;
    logic signed [STATE_BITS-1:0]  low_reg, low_next;

    logic signed [STATE_BITS-1:0]  mul_a;
    logic signed [svf_pkg::COEF_BITS:0] mul_b;
    logic signed [PROD_BITS-1:0]   prod_rounded;
    logic signed [RND_BITS-1:0]    rnd;
    logic signed [SUM_BITS-1:0]    rnd_ext, x_ext, low_ext, band_ext, sum;
    logic signed [STATE_BITS-1:0]  sat_value;

    // Shared multiplier: state value times an unsigned coefficient.
    assign mul_a = (ctrl.cw.mul_a_sel == svf_pkg::MULA_HIGH) ? high_reg : band_reg;
    assign mul_b = (ctrl.cw.coef_sel == svf_pkg::COEF_F) ? $signed({1'b0, freq_coef})
                                                         : $signed({1'b0, damping_coef});

    // Round half up to the state LSB, then drop the fraction bits.
    assign prod_rounded = prod_reg + HALF_LSB;
    assign rnd          = prod_rounded[PROD_BITS-1:COEF_FRAC_BITS];

    assign rnd_ext  = {{(SUM_BITS-RND_BITS){rnd[RND_BITS-1]}}, rnd};
    assign x_ext    = {{(SUM_BITS-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign low_ext  = {{(SUM_BITS-STATE_BITS){low_reg[STATE_BITS-1]}}, low_reg};
    assign band_ext = {{(SUM_BITS-STATE_BITS){band_reg[STATE_BITS-1]}}, band_reg};

    // Accumulate: high subtracts both terms, band and low add the product.
    always_comb
    begin
        case (ctrl.cw.wr_sel)
            svf_pkg::WR_HIGH: sum = x_ext - low_ext - rnd_ext;
            svf_pkg::WR_BAND: sum = band_ext + rnd_ext;
            svf_pkg::WR_LOW:  sum = low_ext + rnd_ext;
            default:          sum = rnd_ext;
        endcase
    end

    // Clamp to the state range.
    always_comb
    begin
        if (sum > SAT_MAX)
            sat_value = SAT_MAX[STATE_BITS-1:0];
        else if (sum < SAT_MIN)
            sat_value = SAT_MIN[STATE_BITS-1:0];
        else
            sat_value = sum[STATE_BITS-1:0];
    end

    // Register updates, only on a step that retires.
    always_comb
    begin
        sample_next = sample_reg;
        prod_next   = prod_reg;
        high_next   = high_reg;
        band_next   = band_reg;
        low_next    = low_reg;
        if (ctrl.fire)
        begin
            if (ctrl.cw.cond == svf_pkg::COND_IN_WORD)
                sample_next = sample_in;
            if (ctrl.cw.mul_en)
                prod_next = mul_a * mul_b;
            case (ctrl.cw.wr_sel)
                svf_pkg::WR_HIGH: high_next = sat_value;
                svf_pkg::WR_BAND: band_next = sat_value;
                svf_pkg::WR_LOW:  low_next  = sat_value;
                default:          ;
            endcase
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        prod_reg   <= prod_next;
        high_reg   <= high_next;
    end

    // The integrators start from zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= '0;
            low_reg  <= '0;
        end
        else
        begin
            band_reg <= band_next;
            low_reg  <= low_next;
        end
    end

    assign high_value = high_reg;
    assign band_value = band_reg;
    assign acc_value  = sat_value;

endmodule
